// ===== design/smdb_pkg.sv =====
// Shared types and constants for the spectrum magnitude / dB converter.
// Used by every module of the block; no dependencies.
`default_nettype none
package smdb_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int BIN_W     = 16;
  localparam int VALUE_W   = 48;
  localparam int POW_W     = 48;
  localparam int MIN_LOG2  = 5;
  localparam int MAX_LOG2  = 16;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;

  // 10*log10(2) in Q.30
  localparam logic [31:0] K_DB = 32'd3232284966;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_OUTPUT_MODE   = 3'd0,
    REG_NORMALIZE     = 3'd1,
    REG_SCALE_TO_UNIT = 3'd2,
    REG_LOG2_FFT_LEN  = 3'd3,
    REG_OUT_LEN       = 3'd4,
    REG_FLOOR_DB      = 3'd5
  } reg_idx_t;

  // what the back end does with a request
  typedef enum logic [1:0] {
    KIND_RAW = 2'd0,  // linear DC / Nyquist pass-through
    KIND_LIN = 2'd1,  // magnitude via square root
    KIND_DB  = 2'd2   // power in dB
  } kind_t;

  typedef struct packed {
    logic                       output_mode;
    logic                       normalize;
    logic                       scale_to_unit;
    logic [4:0]                 log2_len;   // already clamped to 5..16
    logic [15:0]                out_len;
    logic [15:0]                floor_db;
  } cfg_t;

  typedef struct packed {
    kind_t                      kind;
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic [BIN_W-1:0]           bin;
    logic                       last;
  } job_t;

endpackage
`default_nettype wire

// ===== design/smdb_front.sv =====
// Front end: accepts input pairs, tracks the bin counter and turns each pair
// into zero, one or two back-end requests. Depends on smdb_pkg.
`default_nettype none
module smdb_front import smdb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] re_part,
  input  logic signed [SAMPLE_W-1:0] im_part,
  input  logic                       frame_start,
  output logic                       push,
  output job_t                       push_job,
  input  logic                       q_full
);

  logic [14:0] bin_count;
  logic        pend_valid;
  job_t        pend_job;

  logic [15:0] half, half_mask, olen, end_bin, bin;
  logic        nyq, accept, emit_a;
  job_t        job_a, job_n;

  always_comb begin
    half      = 16'd1 << (cfg.log2_len - 5'd1);
    half_mask = half - 16'd1;
    olen      = (cfg.out_len == 16'd0) ? 16'd1 : cfg.out_len;
    end_bin   = ((olen < half) ? olen : half) - 16'd1;
    bin       = frame_start ? 16'd0 : {1'b0, bin_count & half_mask[14:0]};
    nyq       = {1'b0, olen} >= ({1'b0, half} + 17'd1);
    accept    = in_valid && in_ready;
    emit_a    = (bin == 16'd0) || (bin <= end_bin);

    job_a.bin = bin;
    job_a.a   = re_part;
    if (bin == 16'd0) begin
      job_a.kind = cfg.output_mode ? KIND_DB : KIND_RAW;
      job_a.b    = '0;
      job_a.last = (end_bin == 16'd0);
    end else begin
      job_a.kind = cfg.output_mode ? KIND_DB : KIND_LIN;
      job_a.b    = im_part;
      job_a.last = (bin == end_bin);
    end

    job_n.kind = cfg.output_mode ? KIND_DB : KIND_RAW;
    job_n.a    = im_part;
    job_n.b    = '0;
    job_n.bin  = half;
    job_n.last = 1'b0;
  end

  assign in_ready = !pend_valid && !q_full;
  assign push     = pend_valid ? !q_full : (accept && emit_a);
  assign push_job = pend_valid ? pend_job : job_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count  <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (accept) begin
        bin_count <= 15'(bin + 16'd1) & half_mask[14:0];
      end
      if (accept && (bin == 16'd0) && nyq) begin
        pend_valid <= 1'b1;
      end else if (pend_valid && !q_full) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_job <= job_n;
    end
  end

endmodule
`default_nettype wire

// ===== design/smdb_queue.sv =====
// Short request queue between front and back end.
// Depends on smdb_pkg (job_t, QDEPTH).
`default_nettype none
module smdb_queue import smdb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ===== design/smdb_back.sv =====
// Back end: one request at a time through squaring, bit-serial square root,
// log2 by repeated squaring, dB scaling and restoring division. Holds the
// output register. Depends on smdb_pkg.
`default_nettype none
module smdb_back import smdb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  logic                      q_empty,
  input  job_t                      head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [BIN_W-1:0]          out_bin,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      out_last
);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b000000000001,
    ST_MUL   = 12'b000000000010,
    ST_SUM   = 12'b000000000100,
    ST_SQRT  = 12'b000000001000,
    ST_SQFIN = 12'b000000010000,
    ST_NORM  = 12'b000000100000,
    ST_LOG   = 12'b000001000000,
    ST_KMUL  = 12'b000010000000,
    ST_ROUND = 12'b000100000000,
    ST_CLAMP = 12'b001000000000,
    ST_DIV   = 12'b010000000000,
    ST_DONE  = 12'b100000000000
  } state_t;

  state_t                      state;
  job_t                        job;
  logic [POW_W-1:0]            pa, pb, pn;
  logic [95:0]                 rad;
  logic [41:0]                 root;
  logic [43:0]                 rem;
  logic [5:0]                  cnt, e;
  logic [31:0]                 m;
  logic [23:0]                 frac;
  logic                        t_neg;
  logic [62:0]                 kprod;
  logic signed [VALUE_W-1:0]   db, val;
  logic [41:0]                 num;
  logic [23:0]                 drem;

  // combinational helpers
  logic [SAMPLE_W-1:0]         abs_a, abs_b;
  logic [POW_W-1:0]            p;
  logic [23:0]                 floorq;
  logic [5:0]                  twol;
  logic [37:0]                 nterm_full;
  logic [23:0]                 nterm;
  logic [43:0]                 rem_sh, trial;
  logic [41:0]                 mag;
  logic [42:0]                 madd, mshift;
  logic [63:0]                 sq;
  logic [31:0]                 tval, tabs;
  logic [63:0]                 rsum;
  logic signed [VALUE_W-1:0]   neg_floor, dbc, dbsum;
  logic [24:0]                 r2;
  logic                        ge;
  logic                        out_free;

  always_comb begin
    abs_a      = job.a[SAMPLE_W-1] ? SAMPLE_W'(-job.a) : SAMPLE_W'(job.a);
    abs_b      = job.b[SAMPLE_W-1] ? SAMPLE_W'(-job.b) : SAMPLE_W'(job.b);
    p          = pa + pb;
    floorq     = {(cfg.floor_db == 16'd0) ? 16'd1 : cfg.floor_db, 8'd0};
    twol       = {cfg.log2_len, 1'b0};
    nterm_full = 38'(twol) * 38'(K_DB) + 38'd8192;
    nterm      = nterm_full[37:14];
    rem_sh     = {rem[41:0], rad[95:94]};
    trial      = {root, 2'b01};
    mag        = root + 42'(rem > {2'b00, root});
    madd       = {1'b0, mag} + (43'd1 << cfg.log2_len);
    mshift     = madd >> ({1'b0, cfg.log2_len} + 6'd1);
    sq         = {32'd0, m} * {32'd0, m};
    tval       = {2'b00, e, frac} - {2'b00, twol, 24'd0};
    tabs       = tval[31] ? (~tval + 32'd1) : tval;
    rsum       = {1'b0, kprod} + (64'd1 << 37);
    neg_floor  = -$signed({24'd0, floorq});
    dbc        = (db < neg_floor) ? neg_floor : db;
    dbsum      = dbc + $signed({24'd0, floorq});
    r2         = {drem, num[41]};
    ge         = (r2 >= {1'b0, floorq});
    out_free   = !out_valid || out_ready;
  end

  assign pop = (state == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (out_ready)               out_valid <= 1'b0;
      case (state)
        ST_IDLE:  if (!q_empty) state <= ST_MUL;
        ST_MUL:   state <= ST_SUM;
        ST_SUM: begin
          case (job.kind)
            KIND_RAW: state <= ST_DONE;
            KIND_LIN: state <= ST_SQRT;
            KIND_DB:  state <= (p == '0) ? ST_CLAMP : ST_NORM;
            default:  state <= ST_DONE;
          endcase
        end
        ST_SQRT:  if (cnt == 6'd0) state <= ST_SQFIN;
        ST_SQFIN: state <= ST_DONE;
        ST_NORM:  if (pn[POW_W-1]) state <= ST_LOG;
        ST_LOG:   if (cnt == 6'd0) state <= ST_KMUL;
        ST_KMUL:  state <= ST_ROUND;
        ST_ROUND: state <= ST_CLAMP;
        ST_CLAMP: state <= cfg.scale_to_unit ? ST_DIV : ST_DONE;
        ST_DIV:   if (cnt == 6'd0) state <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (!q_empty) job <= head;
      ST_MUL: begin
        pa <= POW_W'(abs_a) * POW_W'(abs_a);
        pb <= POW_W'(abs_b) * POW_W'(abs_b);
      end
      ST_SUM: begin
        val  <= {{(VALUE_W-SAMPLE_W-16){job.a[SAMPLE_W-1]}}, job.a, 16'd0};
        rad  <= {16'd0, p, 32'd0};
        root <= '0;
        rem  <= '0;
        cnt  <= 6'd47;
        pn   <= p;
        e    <= 6'd47;
        db   <= -$signed(48'd13107200) - $signed({24'd0, nterm});
      end
      ST_SQRT: begin
        rad <= {rad[93:0], 2'b00};
        cnt <= cnt - 6'd1;
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[40:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[40:0], 1'b0};
        end
      end
      ST_SQFIN: val <= cfg.normalize ? VALUE_W'(mshift) : VALUE_W'(mag);
      ST_NORM: begin
        if (pn[POW_W-1]) begin
          m    <= pn[POW_W-1 -: 32];
          frac <= '0;
          cnt  <= 6'd23;
        end else begin
          pn <= {pn[POW_W-2:0], 1'b0};
          e  <= e - 6'd1;
        end
      end
      ST_LOG: begin
        cnt <= cnt - 6'd1;
        // m*m back to Q1.31; renormalize when it reaches two
        if (sq[63]) begin
          m    <= sq[63:32];
          frac <= {frac[22:0], 1'b1};
        end else begin
          m    <= sq[62:31];
          frac <= {frac[22:0], 1'b0};
        end
      end
      ST_KMUL: begin
        t_neg <= tval[31];
        kprod <= 63'(tabs[30:0]) * 63'(K_DB);
      end
      ST_ROUND: db <= t_neg ? -$signed(48'(rsum[63:38])) : $signed(48'(rsum[63:38]));
      ST_CLAMP: begin
        val  <= dbc;
        num  <= 42'({dbsum[24:0], 16'd0}) + 42'(floorq[23:1]);
        drem <= '0;
        cnt  <= 6'd41;
      end
      ST_DIV: begin
        drem <= ge ? 24'(r2 - {1'b0, floorq}) : r2[23:0];
        num  <= {num[40:0], ge};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd0) val <= $signed({6'd0, num[40:0], ge});
      end
      ST_DONE: begin
        if (out_free) begin
          out_bin   <= job.bin;
          out_value <= val;
          out_last  <= job.last;
        end
      end
      default: ;
    endcase
  end

  a_log_norm: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOG) |-> m[31])
    else $error("log mantissa lost normalization");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (drem < floorq))
    else $error("divider remainder out of range");

  a_done_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !out_valid) |=> out_valid)
    else $error("finished result not loaded");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== design/spectrum_magnitude_db.sv =====
// Top level of the spectrum magnitude / dB converter: configuration
// registers, front end, request queue and back end. Depends on smdb_pkg.
//
//  channel   | valid / ready       | payload
//  ----------+---------------------+--------------------------------------
//  input     | s_tvalid / s_tready | s_tdata {im_part, re_part}, s_tuser frame_start
//  output    | m_tvalid / m_tready | m_tdata {value, bin_index}, m_tlast last
//  config    | cfg_valid/cfg_ready | cfg_index, cfg_data (ready always high)
//
// Per request: raw pass-through only squares and sums; linear magnitude adds a 48-step
// bit-serial square root; dB adds a normalize shift of up to 47 steps and 24 squaring
// rounds, skipped for zero power, and scale_to_unit adds a 42-step restoring divider.
// The back end handles one request at a time; the front end and a 4-deep
// queue keep taking input while it works. Reset is synchronous and clears
// counters, queue and handshake state; config returns to its defaults.
// Either side may stall freely; the output register holds until taken.
`default_nettype none
module spectrum_magnitude_db import smdb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [23:0] re_part, [47:24] im_part
  input  logic        s_tuser,   // [0] frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [15:0] bin_index, [63:16] value
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic        output_mode, normalize, scale_to_unit;
  logic [4:0]  log2_fft_len;
  logic [15:0] out_len, floor_db;
  cfg_t        cfg;

  logic        push, pop, q_full, q_empty;
  job_t        push_job, head;
  logic [BIN_W-1:0]          out_bin;
  logic signed [VALUE_W-1:0] out_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_mode   <= 1'b1;
      normalize     <= 1'b0;
      scale_to_unit <= 1'b0;
      log2_fft_len  <= 5'd10;
      out_len       <= 16'd513;
      floor_db      <= 16'd25600;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_OUTPUT_MODE:   output_mode   <= cfg_data[0];
        REG_NORMALIZE:     normalize     <= cfg_data[0];
        REG_SCALE_TO_UNIT: scale_to_unit <= cfg_data[0];
        REG_LOG2_FFT_LEN:  log2_fft_len  <= cfg_data[4:0];
        REG_OUT_LEN:       out_len       <= cfg_data;
        REG_FLOOR_DB:      floor_db      <= cfg_data;
        default: ;
      endcase
    end
  end

  // transform length clamped to the supported range
  always_comb begin
    cfg.output_mode   = output_mode;
    cfg.normalize     = normalize;
    cfg.scale_to_unit = scale_to_unit;
    cfg.out_len       = out_len;
    cfg.floor_db      = floor_db;
    if (log2_fft_len < 5'(MIN_LOG2))      cfg.log2_len = 5'(MIN_LOG2);
    else if (log2_fft_len > 5'(MAX_LOG2)) cfg.log2_len = 5'(MAX_LOG2);
    else                                  cfg.log2_len = log2_fft_len;
  end

  smdb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .re_part     (s_tdata[23:0]),
    .im_part     (s_tdata[47:24]),
    .frame_start (s_tuser),
    .push        (push),
    .push_job    (push_job),
    .q_full      (q_full)
  );

  smdb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  smdb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_bin   (out_bin),
    .out_value (out_value),
    .out_last  (m_tlast)
  );

  assign m_tdata = {out_value, out_bin};

endmodule
`default_nettype wire
